/* design/assert_macros.svh */
// Assertion helpers shared by the RTL. Every check is sampled on the rising
// edge of clk and is switched off while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold at every sampled edge.
`define ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// A condition that must hold in the same cycle as its trigger.
`define ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// A condition that must hold in the cycle after its trigger.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* design/iol_pkg.sv */
`timescale 1ns / 1ps
package iol_pkg;

  localparam int DATA_W       = 32;
  localparam int MODE_W       = 3;
  localparam int POS_W        = 7;
  localparam int DEF_CAPACITY = 64;
  localparam int TREE_RADIX   = 8;

  // Request modes. The codes 5 to 7 carry no operation.
  typedef enum logic [MODE_W-1:0] {
    MODE_READ     = 3'd0,
    MODE_INS_HEAD = 3'd1,
    MODE_INS_TAIL = 3'd2,
    MODE_INS_AT   = 3'd3,
    MODE_DELETE   = 3'd4
  } iol_mode_t;

  // Command broadcast to every storage cell.
  typedef struct packed {
    logic              ins;
    logic              del;
    logic [DATA_W-1:0] value;
  } iol_cell_ctrl_t;

  // Number of OR-tree levels needed to cover n leaves.
  function automatic int iol_tree_levels(input int n);
    int lv;
    int span;
    lv   = 1;
    span = TREE_RADIX;
    while (span < n) begin
      lv   = lv + 1;
      span = span * TREE_RADIX;
    end
    return lv;
  endfunction

  // Pipeline stage at which heap node m of the OR tree is loaded. The nodes
  // right above the leaves load first, the root loads last.
  function automatic int iol_node_stage(input int m, input int levels);
    int d;
    int first;
    int span;
    d     = 0;
    first = 0;
    span  = 1;
    while (m >= first + span) begin
      first = first + span;
      span  = span * TREE_RADIX;
      d     = d + 1;
    end
    return levels - 1 - d;
  endfunction

endpackage

/* design/iol_if.sv */
`timescale 1ns / 1ps
// Request channel: one list operation per request.
interface iol_in_if;
  import iol_pkg::*;

  logic                valid;
  logic                ready;
  logic [MODE_W-1:0]   mode;
  logic [POS_W-1:0]    position;
  logic signed [DATA_W-1:0] value_in;

  modport source (output valid, output mode, output position, output value_in,
                  input ready);
  modport sink   (input valid, input mode, input position, input value_in,
                  output ready);
endinterface

// Result channel: one result per request.
interface iol_out_if;
  import iol_pkg::*;

  logic                valid;
  logic                ready;
  logic signed [DATA_W-1:0] read_value;
  logic                op_ok;
  logic [POS_W-1:0]    entry_count;

  modport source (output valid, output read_value, output op_ok, output entry_count,
                  input ready);
  modport sink   (input valid, input read_value, input op_ok, input entry_count,
                  output ready);
endinterface

/* design/iol_cell.sv */
`timescale 1ns / 1ps
module iol_cell #(
  parameter int IDX   = 0,
  parameter int CMP_W = 7
) (
  input  logic                           clk,
  input  iol_pkg::iol_cell_ctrl_t        ctrl,
  input  logic [CMP_W-1:0]               pos,
  input  logic [iol_pkg::DATA_W-1:0]     lower,
  input  logic [iol_pkg::DATA_W-1:0]     upper,
  output logic [iol_pkg::DATA_W-1:0]     data,
  output logic [iol_pkg::DATA_W-1:0]     leaf
);
  import iol_pkg::*;

  localparam logic [CMP_W-1:0] MY_IDX = CMP_W'(IDX);

  logic              hit;
  logic              above;
  logic [DATA_W-1:0] data_r;

  assign hit   = (pos == MY_IDX);
  assign above = (MY_IDX > pos);

  // An insert writes the new value here or takes the neighbor below; a
  // delete takes the neighbor above from the deleted place upward.
  always_ff @(posedge clk) begin
    if (ctrl.ins) begin
      if (hit) begin
        data_r <= ctrl.value;
      end else if (above) begin
        data_r <= lower;
      end
    end else if (ctrl.del && (hit || above)) begin
      data_r <= upper;
    end
  end

  assign data = data_r;

  // Only the addressed cell drives its value into the read tree.
  assign leaf = hit ? data_r : '0;

endmodule

/* design/iol_or_tree.sv */
`timescale 1ns / 1ps
module iol_or_tree #(
  parameter int N = iol_pkg::DEF_CAPACITY
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       load,
  input  logic [iol_pkg::DATA_W-1:0] leaf [N],
  output logic [iol_pkg::DATA_W-1:0] root,
  output logic                       done
);
  import iol_pkg::*;

  localparam int L    = iol_tree_levels(N);
  localparam int PAD  = TREE_RADIX ** L;
  localparam int NODES = (PAD - 1) / (TREE_RADIX - 1);

  logic [DATA_W-1:0] leaf_pad [PAD];
  logic [DATA_W-1:0] kid      [NODES][TREE_RADIX];
  logic [DATA_W-1:0] node_or  [NODES];
  logic [DATA_W-1:0] node_r   [NODES];
  logic [NODES-1:0]  node_en;
  logic [L-1:0]      stage_en;
  logic [L-1:0]      en_r;

  // Leaves past the last cell read as zero.
  for (genvar p = 0; p < PAD; p++) begin : g_pad
    if (p < N) begin : g_used
      assign leaf_pad[p] = leaf[p];
    end else begin : g_zero
      assign leaf_pad[p] = '0;
    end
  end

  // Heap layout: the children of node m are RADIX*m+1 .. RADIX*m+RADIX.
  for (genvar m = 0; m < NODES; m++) begin : g_node
    localparam int S = iol_node_stage(m, L);
    for (genvar c = 0; c < TREE_RADIX; c++) begin : g_kid
      localparam int CH = TREE_RADIX * m + 1 + c;
      if (CH >= NODES) begin : g_leaf
        assign kid[m][c] = leaf_pad[CH - NODES];
      end else begin : g_inner
        assign kid[m][c] = node_r[CH];
      end
    end
    assign node_en[m] = stage_en[S];
  end

  // Each node ORs its children; at most one leaf is nonzero.
  always_comb begin
    for (int m = 0; m < NODES; m++) begin
      node_or[m] = '0;
      for (int c = 0; c < TREE_RADIX; c++) begin
        node_or[m] = node_or[m] | kid[m][c];
      end
    end
  end

  // Stage enables ripple one level per cycle toward the root.
  assign stage_en[0] = load;
  for (genvar s = 1; s < L; s++) begin : g_stage
    assign stage_en[s] = en_r[s-1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_r <= '0;
    end else begin
      en_r <= stage_en;
    end
  end

  // Each level holds its value until the next request reaches it.
  always_ff @(posedge clk) begin
    for (int m = 0; m < NODES; m++) begin
      if (node_en[m]) begin
        node_r[m] <= node_or[m];
      end
    end
  end

  assign root = node_r[0];
  assign done = en_r[L-1];

endmodule

/* design/indexed_ordered_list_top.sv */
`timescale 1ns / 1ps
// Channel   Port     Direction  Payload
// request   in_req   in         mode, position, value_in
// result    out_rsp  out        read_value, op_ok, entry_count
//
// One request is in flight at a time. Its result passes the registered OR
// tree on the read path, of depth L = ceil(log8(CAPACITY)) levels.
// Inserts and deletes shift the cells at and above the position in the single cycle of acceptance.
// Reset (rst_n low, synchronous) empties the list; stored values are not cleared.
// A stalled result holds, and no request is taken until it is delivered.
`include "assert_macros.svh"

module indexed_ordered_list_top #(
  parameter int CAPACITY = iol_pkg::DEF_CAPACITY
) (
  input logic      clk,
  input logic      rst_n,
  iol_in_if.sink   in_req,
  iol_out_if.source out_rsp
);
  import iol_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  logic [CNT_W-1:0]  count_r;
  logic [CNT_W-1:0]  count_nxt;
  logic              busy_r;
  logic              out_valid_r;
  logic              ok_r;
  logic              rd_r;
  logic              in_acc;
  logic              out_acc;
  logic              full;
  logic [CMP_W-1:0]  pos_ext;
  logic [CMP_W-1:0]  cnt_ext;
  logic [CMP_W-1:0]  cell_pos;
  logic              ins_ok;
  logic              del_ok;
  logic              rd_ok;
  logic              tree_done;
  logic [DATA_W-1:0] tree_root;
  iol_cell_ctrl_t    cell_ctrl;
  logic [DATA_W-1:0] cell_data [CAPACITY];
  logic [DATA_W-1:0] cell_leaf [CAPACITY];
  logic [DATA_W-1:0] lower_d   [CAPACITY];
  logic [DATA_W-1:0] upper_d   [CAPACITY];

  assign in_acc  = in_req.valid && !busy_r;
  assign out_acc = out_valid_r && out_rsp.ready;

  assign pos_ext = CMP_W'(in_req.position);
  assign cnt_ext = CMP_W'(count_r);
  assign full    = (count_r == CNT_W'(CAPACITY));

  // Decode the request against the current count.
  always_comb begin
    ins_ok   = 1'b0;
    del_ok   = 1'b0;
    rd_ok    = 1'b0;
    cell_pos = pos_ext;
    case (iol_mode_t'(in_req.mode))
      MODE_READ: begin
        rd_ok = (pos_ext < cnt_ext);
      end
      MODE_INS_HEAD: begin
        cell_pos = '0;
        ins_ok   = !full;
      end
      MODE_INS_TAIL: begin
        cell_pos = cnt_ext;
        ins_ok   = !full;
      end
      MODE_INS_AT: begin
        ins_ok = !full && (pos_ext <= cnt_ext);
      end
      MODE_DELETE: begin
        del_ok = (pos_ext < cnt_ext);
      end
      default: begin
        cell_pos = pos_ext;
      end
    endcase
  end

  assign cell_ctrl.ins   = in_acc && ins_ok;
  assign cell_ctrl.del   = in_acc && del_ok;
  assign cell_ctrl.value = in_req.value_in;

  // Next count after an accepted request.
  always_comb begin
    count_nxt = count_r;
    if (cell_ctrl.ins) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (cell_ctrl.del) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  // Row of storage cells, each wired to its two neighbors.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign lower_d[i] = '0;
    end else begin : g_low
      assign lower_d[i] = cell_data[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign upper_d[i] = cell_data[i];
    end else begin : g_up
      assign upper_d[i] = cell_data[i+1];
    end

    iol_cell #(
      .IDX   (i),
      .CMP_W (CMP_W)
    ) u_cell (
      .clk   (clk),
      .ctrl  (cell_ctrl),
      .pos   (cell_pos),
      .lower (lower_d[i]),
      .upper (upper_d[i]),
      .data  (cell_data[i]),
      .leaf  (cell_leaf[i])
    );
  end

  // Registered OR tree gathers the addressed cell's value.
  iol_or_tree #(
    .N (CAPACITY)
  ) u_tree (
    .clk   (clk),
    .rst_n (rst_n),
    .load  (in_acc),
    .leaf  (cell_leaf),
    .root  (tree_root),
    .done  (tree_done)
  );

  // Control flags and result status.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (in_acc) begin
        busy_r <= 1'b1;
      end else if (out_acc) begin
        busy_r <= 1'b0;
      end
      if (tree_done) begin
        out_valid_r <= 1'b1;
      end else if (out_acc) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      ok_r <= rd_ok || ins_ok || del_ok;
      rd_r <= rd_ok;
    end
  end

  assign in_req.ready        = !busy_r;
  assign out_rsp.valid       = out_valid_r;
  assign out_rsp.read_value  = rd_r ? tree_root : '1;
  assign out_rsp.op_ok       = ok_r;
  assign out_rsp.entry_count = POS_W'(count_r);

  // Checks on the control logic.
  `ASSERT_ALWAYS(a_count_bound, count_r <= CNT_W'(CAPACITY), "count above capacity")
  `ASSERT_SAME(a_valid_busy, out_valid_r, busy_r, "result pending while idle")
  `ASSERT_SAME(a_done_slot, tree_done, busy_r && !out_valid_r, "read data with no open slot")
  `ASSERT_NEXT(a_ins_count, cell_ctrl.ins, count_r == $past(count_r) + CNT_W'(1), "insert lost count")

endmodule

/* sim/tb_indexed_ordered_list_top.sv */
`timescale 1ns / 1ps
module tb_indexed_ordered_list_top;
  import iol_pkg::*;

  localparam int CLK_PERIOD     = 8;
  localparam int CAPACITY       = DEF_CAPACITY;
  localparam int POS_MAX        = (1 << POS_W) - 1;
  localparam int IDLE_PCT       = 8;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 12;

  // Mode codes that carry no operation.
  localparam logic [MODE_W-1:0] MODE_SPARE_LO  = 3'd5;
  localparam logic [MODE_W-1:0] MODE_SPARE_MID = 3'd6;
  localparam logic [MODE_W-1:0] MODE_SPARE_HI  = 3'd7;

  // Value reported for anything other than a successful read.
  localparam logic signed [DATA_W-1:0] NO_VALUE = -1;

  typedef struct {
    logic signed [DATA_W-1:0] read_value;
    logic                     op_ok;
    logic [POS_W-1:0]         entry_count;
  } list_rsp_t;

  logic clk = 1'b0;
  logic rst_n;

  iol_in_if  req_if ();
  iol_out_if rsp_if ();

  indexed_ordered_list_top #(.CAPACITY(CAPACITY)) uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (req_if),
    .out_rsp (rsp_if)
  );

  // Mirror of the list contents and the results still owed by the block.
  logic signed [DATA_W-1:0] list_vals [CAPACITY];
  int                       list_len;
  list_rsp_t                list_rsp_q [$];

  int fail_count  = 0;
  int idle_cycles = 0;
  bit stall_free  = 1'b0;

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Apply one request to the mirrored list and return the result it must give.
  function automatic list_rsp_t apply_list_op(input logic [MODE_W-1:0] mode,
                                              input logic [POS_W-1:0] pos,
                                              input logic signed [DATA_W-1:0] val);
    list_rsp_t r;
    int        p;
    int        ins_pos;
    int        i;
    p            = int'(pos);
    r.read_value = NO_VALUE;
    r.op_ok      = 1'b0;
    ins_pos      = -1;
    case (mode)
      MODE_READ: begin
        if (p < list_len) begin
          r.read_value = list_vals[p];
          r.op_ok      = 1'b1;
        end
      end
      MODE_INS_HEAD: ins_pos = 0;
      MODE_INS_TAIL: ins_pos = list_len;
      MODE_INS_AT:   ins_pos = p;
      MODE_DELETE: begin
        if (p < list_len) begin
          for (i = p; i + 1 < list_len; i++) list_vals[i] = list_vals[i + 1];
          list_len--;
          r.op_ok = 1'b1;
        end
      end
      default: ;
    endcase
    // Inserts succeed only with room left and a position no further than the tail.
    if (ins_pos >= 0 && list_len < CAPACITY && ins_pos <= list_len) begin
      for (i = list_len; i > ins_pos; i--) list_vals[i] = list_vals[i - 1];
      list_vals[ins_pos] = val;
      list_len++;
      r.op_ok = 1'b1;
    end
    r.entry_count = list_len[POS_W-1:0];
    return r;
  endfunction

  // Offer one request, wait for it to be taken, then record its result.
  task automatic send_list_op(input logic [MODE_W-1:0] mode, input logic [POS_W-1:0] pos,
                              input logic signed [DATA_W-1:0] val);
    if (!stall_free && $urandom_range(0, 99) < IDLE_PCT) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    req_if.valid    <= 1'b1;
    req_if.mode     <= mode;
    req_if.position <= pos;
    req_if.value_in <= val;
    do @(posedge clk); while (!req_if.ready);
    list_rsp_q.push_back(apply_list_op(mode, pos, val));
  endtask

  // One random request; grow_pct steers edits toward inserts or deletes.
  task automatic random_list_op(input int grow_pct);
    int                  pick;
    logic [MODE_W-1:0]   mode;
    logic [POS_W-1:0]    pos;
    logic signed [DATA_W-1:0] val;
    pick = $urandom_range(0, 99);
    val  = $urandom;
    if (pick < 8) begin
      // Noise: any mode code, any position.
      mode = MODE_W'($urandom);
      pos  = POS_W'($urandom);
    end else if (pick < 30) begin
      mode = MODE_READ;
      pos  = (list_len > 0) ? POS_W'($urandom_range(0, list_len - 1)) : '0;
    end else if ($urandom_range(0, 99) < grow_pct) begin
      case ($urandom_range(0, 2))
        0:       mode = MODE_INS_HEAD;
        1:       mode = MODE_INS_TAIL;
        default: mode = MODE_INS_AT;
      endcase
      pos = POS_W'($urandom_range(0, list_len));
    end else begin
      mode = MODE_DELETE;
      pos  = (list_len > 0) ? POS_W'($urandom_range(0, list_len - 1)) : POS_W'($urandom);
    end
    send_list_op(mode, pos, val);
  endtask

  // Operations on an empty list, out-of-range positions and spare mode codes.
  task automatic test_empty_list();
    send_list_op(MODE_READ, 0, 0);
    send_list_op(MODE_READ, POS_MAX, 0);
    send_list_op(MODE_DELETE, 0, 0);
    send_list_op(MODE_INS_AT, 1, 32'h1234_5678);
    send_list_op(MODE_SPARE_LO, POS_MAX, -1);
    send_list_op(MODE_SPARE_MID, 0, 32'h7FFF_FFFF);
    send_list_op(MODE_SPARE_HI, CAPACITY, 32'h8000_0000);
  endtask

  // Inserts of extreme values at every kind of place, then reads and deletes.
  task automatic test_directed_edits();
    send_list_op(MODE_INS_AT, 0, 32'h7FFF_FFFF);
    send_list_op(MODE_INS_HEAD, POS_MAX, 32'h8000_0000);
    send_list_op(MODE_INS_TAIL, POS_MAX, -1);
    send_list_op(MODE_INS_AT, 3, 0);
    send_list_op(MODE_INS_AT, 1, 32'h5555_5555);
    send_list_op(MODE_INS_AT, 7, 32'h2AAA_AAAA);
    for (int i = 0; i < 5; i++) send_list_op(MODE_READ, POS_W'(i), $urandom);
    send_list_op(MODE_READ, 5, 0);
    send_list_op(MODE_DELETE, 5, 0);
    send_list_op(MODE_DELETE, 0, 0);
    send_list_op(MODE_DELETE, 3, 0);
    send_list_op(MODE_DELETE, 1, 0);
    send_list_op(MODE_READ, 0, 0);
    send_list_op(MODE_READ, 1, 0);
  endtask

  // Fill to capacity, check that every insert is then refused, edit at the top.
  task automatic test_full_list();
    while (list_len < CAPACITY) random_list_op(100);
    send_list_op(MODE_INS_HEAD, 0, $urandom);
    send_list_op(MODE_INS_TAIL, 0, $urandom);
    send_list_op(MODE_INS_AT, 0, $urandom);
    send_list_op(MODE_INS_AT, CAPACITY, $urandom);
    send_list_op(MODE_READ, CAPACITY - 1, 0);
    send_list_op(MODE_READ, CAPACITY, 0);
    send_list_op(MODE_DELETE, CAPACITY, 0);
    send_list_op(MODE_DELETE, CAPACITY - 1, 0);
    send_list_op(MODE_INS_AT, CAPACITY - 1, $urandom);
    send_list_op(MODE_READ, CAPACITY - 1, 0);
  endtask

  // Random traffic in phases that alternately favour inserts and deletes.
  task automatic test_random_traffic();
    repeat (160) random_list_op(80);
    repeat (140) random_list_op(20);
    repeat (120) random_list_op(85);
    repeat (120) random_list_op(15);
  endtask

  // A stretch with neither side idling.
  task automatic test_back_to_back();
    stall_free = 1'b1;
    repeat (150) random_list_op(50);
    stall_free = 1'b0;
  endtask

  // Delete from random places until the list is empty.
  task automatic test_drain_to_empty();
    while (list_len > 0) begin
      send_list_op(MODE_DELETE, POS_W'($urandom_range(0, list_len - 1)), $urandom);
    end
    send_list_op(MODE_READ, 0, 0);
    send_list_op(MODE_DELETE, 0, 0);
  endtask

  // The result side stalls at random except during the back-to-back stretch.
  always @(posedge clk) begin
    rsp_if.ready <= stall_free || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  // Compare each delivered result with the oldest one owed.
  always @(posedge clk) begin
    list_rsp_t want;
    if (rst_n && rsp_if.valid && rsp_if.ready) begin
      if (list_rsp_q.size() == 0) begin
        $error("result delivered with no request outstanding");
        fail_count++;
      end else begin
        want = list_rsp_q.pop_front();
        if (rsp_if.read_value !== want.read_value) begin
          $error("read_value: expected %0d, got %0d", want.read_value, rsp_if.read_value);
          fail_count++;
        end
        if (rsp_if.op_ok !== want.op_ok) begin
          $error("op_ok: expected %0b, got %0b", want.op_ok, rsp_if.op_ok);
          fail_count++;
        end
        if (rsp_if.entry_count !== want.entry_count) begin
          $error("entry_count: expected %0d, got %0d", want.entry_count, rsp_if.entry_count);
          fail_count++;
        end
      end
    end
  end

  // End the run if nothing moves on either channel for too long.
  always @(posedge clk) begin
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst_n           = 1'b0;
    req_if.valid    = 1'b0;
    req_if.mode     = MODE_READ;
    req_if.position = '0;
    req_if.value_in = '0;
    rsp_if.ready    = 1'b0;
    list_len        = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    test_empty_list();
    test_directed_edits();
    test_full_list();
    test_random_traffic();
    test_back_to_back();
    test_drain_to_empty();

    req_if.valid <= 1'b0;
    while (list_rsp_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0 && list_rsp_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
